[rtl/sorted_unique_value_set_assert.svh]
// Assertion macros used by the sorted value set top module.
`ifndef SORTED_UNIQUE_VALUE_SET_ASSERT_SVH
`define SORTED_UNIQUE_VALUE_SET_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SUVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SUVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/suvs_pkg.sv]
// Types, codes and widths shared by the sorted value set modules.
package suvs_pkg;

    localparam int DEPTH_DEF  = 32;
    localparam int OP_W       = 3;
    localparam int VAL_W      = 64;
    localparam int ROW_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 6;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_ERASE_VAL = 3'd1,
        OP_ERASE_ROW = 3'd2,
        OP_REPLACE   = 3'd3,
        OP_CLEAR     = 3'd4,
        OP_READ      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_OOB  = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    // What every cell does with its contents this cycle.
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_INS,
        ACT_DEL
    } act_t;

    // Which per-cell flag marks the cell where the chain action starts.
    typedef enum logic [1:0] {
        MARK_INS,
        MARK_ROW,
        MARK_EQ
    } mark_t;

    typedef struct packed {
        logic                    cap;
        logic                    no_gt;
        act_t                    act;
        mark_t                   mark;
        logic signed [VAL_W-1:0] value;
    } cell_ctl_t;

endpackage

[rtl/suvs_cell.sv]
// One storage cell of the value chain: entry, compare flags and shift muxing.
module suvs_cell #(
    parameter int DEPTH = suvs_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  suvs_pkg::cell_ctl_t               ctl,
    input  logic [$clog2(DEPTH+1)-1:0]        count,
    input  logic [suvs_pkg::ROW_W-1:0]        row,
    input  logic signed [suvs_pkg::VAL_W-1:0] prev_data,
    input  logic signed [suvs_pkg::VAL_W-1:0] next_data,
    input  logic                              next_eq,
    input  logic                              pfx_in,
    output logic                              pfx_out,
    output logic                              first,
    output logic signed [suvs_pkg::VAL_W-1:0] data,
    output logic                              eq,
    output logic [suvs_pkg::VAL_W-1:0]        rd_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = suvs_pkg::ROW_W + CW;

    logic signed [suvs_pkg::VAL_W-1:0] data_reg, data_next;
    logic                              eq_reg, eq_next;
    logic                              gt_reg, gt_next;
    logic                              occ, sel, mark;

    assign occ = CW'(IDX) < count;
    assign sel = SW'(row) == SW'(IDX);

    always_comb
    begin
        unique case (ctl.mark)
            suvs_pkg::MARK_INS: mark = gt_reg || !occ;
            suvs_pkg::MARK_ROW: mark = sel;
            suvs_pkg::MARK_EQ:  mark = eq_reg;
            default:            mark = 1'b0;
        endcase
    end

    assign pfx_out = pfx_in | mark;
    assign first   = mark & ~pfx_in;

    always_comb
    begin
        data_next = data_reg;
        eq_next   = eq_reg;
        gt_next   = gt_reg;
        if (ctl.cap)
        begin
            eq_next = occ && (data_reg == ctl.value);
            gt_next = occ && !ctl.no_gt && (data_reg > ctl.value);
        end
        unique case (ctl.act)
            suvs_pkg::ACT_INS:
            begin
                // open a slot at the first mark, push the tail one row up
                if (first)
                    data_next = ctl.value;
                else if (pfx_in)
                    data_next = prev_data;
            end
            suvs_pkg::ACT_DEL:
            begin
                // close the gap: everything from the mark on moves one row down
                if (pfx_out)
                begin
                    data_next = next_data;
                    eq_next   = next_eq;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eq_reg <= 1'b0;
            gt_reg <= 1'b0;
        end
        else
        begin
            eq_reg <= eq_next;
            gt_reg <= gt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign eq      = eq_reg;
    assign rd_data = sel ? data_reg : '0;

endmodule

[rtl/sorted_unique_value_set.sv]
// Bounded sorted/append value list built from a chain of shifting cells.
//
//  channel | signals                    | direction | payload
//  --------+----------------------------+-----------+---------------------------------
//  s_      | s_tvalid s_tready s_tdata  | in        | op, value, row
//  m_      | m_tvalid m_tready m_tdata  | out       | status, result_row, read_value,
//          |                            |           | entry_count
//  cfg_    | cfg_valid cfg_ready        | in        | preserve_order
//
//  One item at a time. Every item passes through an execute state and then a done state
//  that loads the result register; insert adds an insert state; replace row adds a
//  compare state and an insert state; erase value stays in its erase state, where the
//  cell chain removes one match per cycle until none is left. Insert runs the broadcast
//  compare first and then the prefix chain that places the value.
//  Reset clears the count and mode; entry contents are not cleared. A held result does
//  not block the next beat, which waits in the last state until the output frees up.
module sorted_unique_value_set #(
    parameter int DEPTH = suvs_pkg::DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [2:0] op, [66:3] value, [71:67] row
    input  logic [suvs_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] status, [6:2] result_row, [70:7] read_value, [76:71] entry_count
    output logic [suvs_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data
);

    `include "sorted_unique_value_set_assert.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = suvs_pkg::VAL_W;
    localparam int RW = suvs_pkg::ROW_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REPCAP,
        S_INS,
        S_ERV,
        S_DONE
    } state_t;

    state_t                      state_reg;
    suvs_pkg::op_t               op_reg;
    logic signed [VW-1:0]        value_reg;
    logic [RW-1:0]               row_reg;
    logic                        preserve_reg;
    logic [CW-1:0]               count_reg;
    suvs_pkg::status_t           res_status_reg;
    logic [RW-1:0]               res_row_reg;
    logic [VW-1:0]               res_rdata_reg;
    logic                        m_tvalid_reg;
    logic [suvs_pkg::STATUS_W-1:0]  out_status_reg;
    logic [RW-1:0]               out_row_reg;
    logic [VW-1:0]               out_rdata_reg;
    logic [suvs_pkg::CNT_OUT_W-1:0] out_cnt_reg;

    suvs_pkg::cell_ctl_t         ctl;
    logic signed [VW-1:0]        data_w   [DEPTH];
    logic [VW-1:0]               rd_w     [DEPTH];
    logic [DEPTH-1:0]            eq_w;
    logic [DEPTH-1:0]            first_w;
    logic [DEPTH:0]              pfx_w;

    logic [VW-1:0]               rd_or;
    logic [AW-1:0]               pos;
    logic                        any_eq;
    logic                        row_oob;
    logic                        full;
    logic [RW-1:0]               pos_row;
    logic [CW+RW-1:0]            pos_w;
    logic [CW+suvs_pkg::CNT_OUT_W-1:0] cnt_w;

    assign pfx_w[0] = 1'b0;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic signed [VW-1:0] prev_d, next_d;
        logic                 next_e;

        if (k == 0)
        begin : g_head
            assign prev_d = '0;
        end
        else
        begin : g_body
            assign prev_d = data_w[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_tail
            assign next_d = '0;
            assign next_e = 1'b0;
        end
        else
        begin : g_link
            assign next_d = data_w[k+1];
            assign next_e = eq_w[k+1];
        end

        suvs_cell #(
            .DEPTH (DEPTH),
            .IDX   (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .count     (count_reg),
            .row       (row_reg),
            .prev_data (prev_d),
            .next_data (next_d),
            .next_eq   (next_e),
            .pfx_in    (pfx_w[k]),
            .pfx_out   (pfx_w[k+1]),
            .first     (first_w[k]),
            .data      (data_w[k]),
            .eq        (eq_w[k]),
            .rd_data   (rd_w[k])
        );
    end

    // collect read data, first-mark position and match flag across the chain
    always_comb
    begin
        rd_or  = '0;
        pos    = '0;
        any_eq = 1'b0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_or  = rd_or | rd_w[k];
            pos    = pos | (first_w[k] ? AW'(k) : '0);
            any_eq = any_eq | eq_w[k];
        end
    end

    assign row_oob = (CW+RW)'(row_reg) >= (CW+RW)'(count_reg);
    assign full    = count_reg == CW'(DEPTH);
    assign pos_w   = (CW+RW)'(pos);
    assign pos_row = pos_w[RW-1:0];
    assign cnt_w   = (CW+suvs_pkg::CNT_OUT_W)'(count_reg);

    always_comb
    begin
        ctl       = '0;
        ctl.no_gt = preserve_reg;
        ctl.act   = suvs_pkg::ACT_HOLD;
        ctl.mark  = suvs_pkg::MARK_INS;
        ctl.value = value_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                unique case (op_reg)
                    suvs_pkg::OP_INSERT,
                    suvs_pkg::OP_ERASE_VAL:
                        ctl.cap = 1'b1;
                    suvs_pkg::OP_ERASE_ROW,
                    suvs_pkg::OP_REPLACE:
                    begin
                        if (!row_oob)
                        begin
                            ctl.mark = suvs_pkg::MARK_ROW;
                            ctl.act  = suvs_pkg::ACT_DEL;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_REPCAP:
                ctl.cap = 1'b1;
            S_INS:
            begin
                if (!preserve_reg && any_eq)
                    ctl.mark = suvs_pkg::MARK_EQ;
                else if (!full)
                    ctl.act = suvs_pkg::ACT_INS;
            end
            S_ERV:
            begin
                ctl.mark = suvs_pkg::MARK_EQ;
                if (any_eq)
                    ctl.act = suvs_pkg::ACT_DEL;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= suvs_pkg::OP_INSERT;
            value_reg      <= '0;
            row_reg        <= '0;
            preserve_reg   <= 1'b0;
            count_reg      <= '0;
            res_status_reg <= suvs_pkg::STAT_OK;
            res_row_reg    <= '0;
            res_rdata_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            out_status_reg <= '0;
            out_row_reg    <= '0;
            out_rdata_reg  <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
                preserve_reg <= cfg_data;
            // drop a taken beat; a finished item reloads the output in the same cycle
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= suvs_pkg::op_t'(s_tdata[2:0]);
                        value_reg <= s_tdata[66:3];
                        row_reg   <= s_tdata[71:67];
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (op_reg == suvs_pkg::OP_READ && !row_oob)
                        res_rdata_reg <= rd_or;
                    else
                        res_rdata_reg <= '0;
                    unique case (op_reg)
                        suvs_pkg::OP_INSERT:
                        begin
                            res_status_reg <= suvs_pkg::STAT_OK;
                            res_row_reg    <= '0;
                            state_reg      <= S_INS;
                        end
                        suvs_pkg::OP_ERASE_VAL:
                        begin
                            res_status_reg <= suvs_pkg::STAT_OK;
                            res_row_reg    <= '0;
                            state_reg      <= S_ERV;
                        end
                        suvs_pkg::OP_ERASE_ROW:
                        begin
                            res_row_reg <= row_reg;
                            state_reg   <= S_DONE;
                            if (row_oob)
                                res_status_reg <= suvs_pkg::STAT_OOB;
                            else
                            begin
                                res_status_reg <= suvs_pkg::STAT_OK;
                                count_reg      <= count_reg - CW'(1);
                            end
                        end
                        suvs_pkg::OP_REPLACE:
                        begin
                            res_row_reg <= row_reg;
                            if (row_oob)
                            begin
                                res_status_reg <= suvs_pkg::STAT_OOB;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                res_status_reg <= suvs_pkg::STAT_OK;
                                count_reg      <= count_reg - CW'(1);
                                state_reg      <= S_REPCAP;
                            end
                        end
                        suvs_pkg::OP_CLEAR:
                        begin
                            res_status_reg <= suvs_pkg::STAT_OK;
                            res_row_reg    <= '0;
                            count_reg      <= '0;
                            state_reg      <= S_DONE;
                        end
                        suvs_pkg::OP_READ:
                        begin
                            res_row_reg <= row_reg;
                            state_reg   <= S_DONE;
                            if (row_oob)
                                res_status_reg <= suvs_pkg::STAT_OOB;
                            else
                                res_status_reg <= suvs_pkg::STAT_OK;
                        end
                        default:
                        begin
                            res_status_reg <= suvs_pkg::STAT_OK;
                            res_row_reg    <= '0;
                            state_reg      <= S_DONE;
                        end
                    endcase
                end
                S_REPCAP:
                    state_reg <= S_INS;
                S_INS:
                begin
                    // sorted hit returns the first equal row; full drops the value
                    if (!preserve_reg && any_eq)
                        res_row_reg <= pos_row;
                    else if (full)
                    begin
                        res_status_reg <= suvs_pkg::STAT_FULL;
                        res_row_reg    <= '0;
                    end
                    else
                    begin
                        res_row_reg <= pos_row;
                        count_reg   <= count_reg + CW'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_ERV:
                begin
                    // drop one match per cycle until none is left
                    if (any_eq)
                        count_reg <= count_reg - CW'(1);
                    else
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_row_reg    <= res_row_reg;
                        out_rdata_reg  <= res_rdata_reg;
                        out_cnt_reg    <= cnt_w[suvs_pkg::CNT_OUT_W-1:0];
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {3'b000, out_cnt_reg, out_rdata_reg, out_row_reg, out_status_reg};

    `SUVS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "entry count above depth")
    `SUVS_ASSERT_NOW(a_ins_room, ctl.act == suvs_pkg::ACT_INS, !full, "insert shift on full list")
    `SUVS_ASSERT_NOW(a_ins_unique, ctl.act == suvs_pkg::ACT_INS && !preserve_reg, !any_eq,
        "sorted insert of a value already present")
    `SUVS_ASSERT_NEXT(a_del_count, ctl.act == suvs_pkg::ACT_DEL,
        count_reg == $past(count_reg) - CW'(1), "delete shift without count decrement")

endmodule
